@@ src/ksdr_pkg.sv @@
// ----------------------------------------------------------------------------
// ksdr_pkg: shared types and constants for k_shortest_distances_relaxation
// Field widths, sentinel value, register indexes and the item structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ksdr_pkg;

    localparam int VERTEX_W   = 7;
    localparam int WEIGHT_W   = 16;
    localparam int DIST_W     = 20;
    localparam int NUMV_W     = 7;
    localparam int KREG_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [DIST_W-1:0] SENTINEL = DIST_W'(999999);

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int MAX_K_DEF        = 8;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_K_IN_USE     = 1'b1;

    typedef struct packed {
        logic [VERTEX_W-1:0] edge_from;
        logic [VERTEX_W-1:0] edge_to;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                edge_last;
    } edge_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              unreached;
        logic              last_result;
    } result_t;

endpackage

`default_nettype wire

@@ src/k_shortest_distances_relaxation.sv @@
// ----------------------------------------------------------------------------
// k_shortest_distances_relaxation: k shortest distances by edge relaxation
// Stores an edge list, then runs k relaxation passes with one shared
// add/compare unit over a distance memory and reports the target's list.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  edge     | start & !busy              | edge_item (edge_item_t)
//  result   | result_valid (strobe)      | result (result_t)
//  config   | cfg_valid & cfg_ready      | cfg_index, cfg_data
//
//  An edge item is taken whenever start is high while idle. The item marked
//  last starts a run: a clearing sweep over the n*k entries of the distance
//  memory, then for each of the k passes and each stored edge a walk through
//  the distance memory (read edge, read source, read worst, then a step per
//  shifted entry and one to place), then a read and an emit step per result.
//  busy is high for the whole run. Results cannot be stalled; each is shown
//  for one cycle. rst_n clears the edge count and resets the registers at once.
// ----------------------------------------------------------------------------
`default_nettype none

module k_shortest_distances_relaxation #(
    parameter int MAX_VERTICES = ksdr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = ksdr_pkg::MAX_EDGES_DEF,
    parameter int MAX_K        = ksdr_pkg::MAX_K_DEF,
    parameter int WEIGHT_BITS  = ksdr_pkg::WEIGHT_BITS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  ksdr_pkg::edge_item_t               edge_item,
    output logic                               result_valid,
    output ksdr_pkg::result_t                  result,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [ksdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [ksdr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ksdr_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES + 1);
    localparam int KW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KCW = $clog2(MAX_K + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int EDW = 2 * VERTEX_W + WEIGHT_BITS;
    localparam int SW  = DIST_W + 1;
    localparam int DD  = 1 << (VW + KW);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_SRC_CHK,
        S_WORST_CHK,
        S_SHIFT_CHK,
        S_PLACE,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    state_t               state_reg;
    logic [NUMV_W-1:0]    num_vertices_reg;
    logic [KREG_W-1:0]    k_in_use_reg;
    logic [NUMV_W-1:0]    n_eff_reg;
    logic [KCW-1:0]       k_eff_reg;
    logic [CW-1:0]        edge_count_reg;
    logic [CW-1:0]        e_reg;
    logic [KCW-1:0]       s_reg;
    logic [KCW-1:0]       x_reg;
    logic [KCW-1:0]       clr_s_reg;
    logic [VW-1:0]        clr_v_reg;
    logic [SW-1:0]        sum_reg;
    logic                 result_valid_reg;
    result_t              result_reg;

    logic [EDW-1:0]       edge_mem [MAX_EDGES];
    logic [EDW-1:0]       edge_rdata_reg;
    logic [DIST_W-1:0]    dist_mem [DD];
    logic [DIST_W-1:0]    dist_rdata_reg;

    logic [NUMV_W-1:0]    n_eff_next;
    logic [KCW-1:0]       k_eff_next;
    logic [VERTEX_W-1:0]  ed_from;
    logic [VERTEX_W-1:0]  ed_to;
    logic [WEIGHT_BITS-1:0] ed_wt;
    logic [VW-1:0]        src_v;
    logic [VW-1:0]        dst_v;
    logic                 edge_ok;
    logic [KCW-1:0]       k_last;
    logic [KCW-1:0]       k_last2;
    logic [KCW-1:0]       x_m1;
    logic [KCW-1:0]       x_m2;
    logic                 less;
    logic                 src_unreached;
    logic                 last_edge;
    logic                 last_pass;
    logic                 advance;
    logic                 load_ok;
    logic [VW+KW-1:0]     dist_rd_addr;
    logic                 dist_we;
    logic [VW+KW-1:0]     dist_wr_addr;
    logic [DIST_W-1:0]    dist_wr_data;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (num_vertices_reg == '0)
            n_eff_next = NUMV_W'(1);
        else if (int'(num_vertices_reg) > MAX_VERTICES)
            n_eff_next = NUMV_W'(MAX_VERTICES);
        else
            n_eff_next = num_vertices_reg;

        if (k_in_use_reg == '0)
            k_eff_next = KCW'(1);
        else if (int'(k_in_use_reg) > MAX_K)
            k_eff_next = KCW'(MAX_K);
        else
            k_eff_next = KCW'(k_in_use_reg);
    end

    assign ed_from = edge_rdata_reg[EDW-1 -: VERTEX_W];
    assign ed_to   = edge_rdata_reg[EDW-1-VERTEX_W -: VERTEX_W];
    assign ed_wt   = edge_rdata_reg[WEIGHT_BITS-1:0];
    assign src_v   = VW'(ed_from);
    assign dst_v   = VW'(ed_to);
    assign edge_ok = (ed_from != '0) && (ed_from <= n_eff_reg)
                  && (ed_to != '0) && (ed_to <= n_eff_reg);

    assign k_last  = KCW'(k_eff_reg - KCW'(1));
    assign k_last2 = KCW'(k_eff_reg - KCW'(2));
    assign x_m1    = KCW'(x_reg - KCW'(1));
    assign x_m2    = KCW'(x_reg - KCW'(2));

    assign less          = (sum_reg < {1'b0, dist_rdata_reg});
    assign src_unreached = (dist_rdata_reg == SENTINEL);
    assign last_edge     = (CW'(e_reg + CW'(1)) == edge_count_reg);
    assign last_pass     = (KCW'(s_reg + KCW'(1)) == k_eff_reg);
    assign load_ok       = (edge_count_reg < CW'(MAX_EDGES));

    always_comb
    begin
        case (state_reg)
            S_EDGE_CHK:  advance = !edge_ok;
            S_SRC_CHK:   advance = src_unreached;
            S_WORST_CHK: advance = !less || (k_eff_reg == KCW'(1));
            S_SHIFT_CHK: advance = !less;
            S_PLACE:     advance = 1'b1;
            default:     advance = 1'b0;
        endcase
    end

    always_comb
    begin
        dist_rd_addr = '0;
        dist_we      = 1'b0;
        dist_wr_addr = '0;
        dist_wr_data = SENTINEL;
        case (state_reg)
            S_CLEAR:
            begin
                dist_we      = 1'b1;
                dist_wr_addr = {clr_v_reg, clr_s_reg[KW-1:0]};
                dist_wr_data = ((clr_v_reg == VW'(1)) && (clr_s_reg == '0)) ? '0 : SENTINEL;
            end
            S_EDGE_CHK:
                dist_rd_addr = {src_v, s_reg[KW-1:0]};
            S_SRC_CHK:
                dist_rd_addr = {dst_v, k_last[KW-1:0]};
            S_WORST_CHK:
            begin
                dist_rd_addr = {dst_v, k_last2[KW-1:0]};
                if (less && (k_eff_reg == KCW'(1)))
                begin
                    dist_we      = 1'b1;
                    dist_wr_addr = {dst_v, {KW{1'b0}}};
                    dist_wr_data = sum_reg[DIST_W-1:0];
                end
            end
            S_SHIFT_CHK:
            begin
                dist_rd_addr = {dst_v, x_m2[KW-1:0]};
                dist_we      = 1'b1;
                dist_wr_addr = {dst_v, x_reg[KW-1:0]};
                dist_wr_data = less ? dist_rdata_reg : sum_reg[DIST_W-1:0];
            end
            S_PLACE:
            begin
                dist_we      = 1'b1;
                dist_wr_addr = {dst_v, {KW{1'b0}}};
                dist_wr_data = sum_reg[DIST_W-1:0];
            end
            S_OUT_RD:
                dist_rd_addr = {VW'(n_eff_reg), x_reg[KW-1:0]};
            default:
                dist_rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start && load_ok)
            edge_mem[edge_count_reg[EW-1:0]] <= {edge_item.edge_from, edge_item.edge_to,
                                                 WEIGHT_BITS'(edge_item.edge_weight)};
        edge_rdata_reg <= edge_mem[e_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wr_addr] <= dist_wr_data;
        dist_rdata_reg <= dist_mem[dist_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            num_vertices_reg <= NUMV_W'(1);
            k_in_use_reg     <= KREG_W'(1);
            n_eff_reg        <= NUMV_W'(1);
            k_eff_reg        <= KCW'(1);
            edge_count_reg   <= '0;
            e_reg            <= '0;
            s_reg            <= '0;
            x_reg            <= '0;
            clr_s_reg        <= '0;
            clr_v_reg        <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= (state_reg == S_OUT_EMIT);

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NUM_VERTICES: num_vertices_reg <= cfg_data[NUMV_W-1:0];
                    CFG_K_IN_USE:     k_in_use_reg     <= cfg_data[KREG_W-1:0];
                    default:          num_vertices_reg <= num_vertices_reg;
                endcase
            end

            if (advance)
            begin
                // next edge, next pass, or report
                if (last_edge)
                begin
                    e_reg <= '0;
                    if (last_pass)
                    begin
                        edge_count_reg <= '0;
                        x_reg          <= '0;
                        state_reg      <= S_OUT_RD;
                    end
                    else
                    begin
                        s_reg     <= KCW'(s_reg + KCW'(1));
                        state_reg <= S_EDGE_RD;
                    end
                end
                else
                begin
                    e_reg     <= CW'(e_reg + CW'(1));
                    state_reg <= S_EDGE_RD;
                end
            end
            else
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (start)
                        begin
                            if (load_ok)
                                edge_count_reg <= CW'(edge_count_reg + CW'(1));
                            if (edge_item.edge_last)
                            begin
                                n_eff_reg <= n_eff_next;
                                k_eff_reg <= k_eff_next;
                                clr_v_reg <= VW'(1);
                                clr_s_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                        end
                    end
                    S_CLEAR:
                    begin
                        if (clr_s_reg == k_last)
                        begin
                            clr_s_reg <= '0;
                            if (clr_v_reg == VW'(n_eff_reg))
                            begin
                                e_reg     <= '0;
                                s_reg     <= '0;
                                state_reg <= S_EDGE_RD;
                            end
                            else
                                clr_v_reg <= VW'(clr_v_reg + VW'(1));
                        end
                        else
                            clr_s_reg <= KCW'(clr_s_reg + KCW'(1));
                    end
                    S_EDGE_RD:
                        state_reg <= S_EDGE_CHK;
                    S_EDGE_CHK:
                        state_reg <= S_SRC_CHK;
                    S_SRC_CHK:
                    begin
                        sum_reg   <= {1'b0, dist_rdata_reg} + SW'(ed_wt);
                        state_reg <= S_WORST_CHK;
                    end
                    S_WORST_CHK:
                    begin
                        x_reg     <= k_last;
                        state_reg <= S_SHIFT_CHK;
                    end
                    S_SHIFT_CHK:
                    begin
                        x_reg <= x_m1;
                        if (x_reg == KCW'(1))
                            state_reg <= S_PLACE;
                    end
                    S_OUT_RD:
                        state_reg <= S_OUT_EMIT;
                    S_OUT_EMIT:
                    begin
                        result_reg.distance    <= dist_rdata_reg;
                        result_reg.unreached   <= (dist_rdata_reg == SENTINEL);
                        result_reg.last_result <= (x_reg == k_last);
                        x_reg                  <= KCW'(x_reg + KCW'(1));
                        state_reg              <= (x_reg == k_last) ? S_IDLE : S_OUT_RD;
                    end
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ verif/tb_k_shortest_distances_relaxation.sv @@
// ----------------------------------------------------------------------------
// tb_k_shortest_distances_relaxation: self-checking bench for the k shortest
// distances block
// Edge lists are fed through the start/busy port under a range of vertex
// counts and k settings, including out-of-range endpoints, clamped
// register values, a full edge store and sums that reach the unreached
// value. The bench keeps its own copy of the edge list and distance lists,
// works out the target's distances for each run and checks every strobed
// result against them in order.
// ----------------------------------------------------------------------------
module tb_k_shortest_distances_relaxation;
    import ksdr_pkg::*;

    localparam int MAX_V = MAX_VERTICES_DEF;
    localparam int MAX_E = MAX_EDGES_DEF;
    localparam int MAX_KK = MAX_K_DEF;
    localparam int unsigned NO_PATH = SENTINEL;
    localparam int LIMIT = 400000;
    localparam int SETTLE = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    edge_item_t edge_item = '0;
    logic result_valid;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [NUMV_W-1:0] vertices_reg = NUMV_W'(1);
    logic [KREG_W-1:0] k_reg = KREG_W'(1);
    int unsigned held_from [MAX_E];
    int unsigned held_to [MAX_E];
    int unsigned held_weight [MAX_E];
    int unsigned held_count = 0;
    int unsigned dist_lists [MAX_V+1][MAX_KK];

    edge_item_t pending_edges [$];
    result_t target_distances [$];
    int errors = 0;
    int cycles = 0;
    int gap_pct = 0;
    int idle_left = 0;
    bit steady = 1'b0;

    k_shortest_distances_relaxation dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .edge_item(edge_item),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned clamp_count(int unsigned raw, int unsigned cap);
        if (raw == 0)
        begin
            return 1;
        end
        return (raw > cap) ? cap : raw;
    endfunction

    function automatic void load_edge(edge_item_t e);
        int unsigned n;
        int unsigned k;
        int unsigned u;
        int unsigned v;
        int unsigned sum;
        int unsigned swap;
        result_t r;
        if (held_count < MAX_E)
        begin
            held_from[held_count] = e.edge_from;
            held_to[held_count] = e.edge_to;
            held_weight[held_count] = e.edge_weight;
            held_count++;
        end
        if (!e.edge_last)
        begin
            return;
        end
        n = clamp_count(vertices_reg, MAX_V);
        k = clamp_count(k_reg, MAX_KK);
        for (int i = 0; i <= MAX_V; i++)
        begin
            for (int j = 0; j < MAX_KK; j++)
            begin
                dist_lists[i][j] = NO_PATH;
            end
        end
        dist_lists[1][0] = 0;
        for (int s = 0; s < int'(k); s++)
        begin
            for (int idx = 0; idx < int'(held_count); idx++)
            begin
                u = held_from[idx];
                v = held_to[idx];
                if (u == 0 || u > n || v == 0 || v > n)
                begin
                    continue;
                end
                if (dist_lists[u][s] == NO_PATH)
                begin
                    continue;
                end
                sum = dist_lists[u][s] + held_weight[idx];
                if (sum >= dist_lists[v][k-1])
                begin
                    continue;
                end
                dist_lists[v][k-1] = sum;
                for (int x = int'(k) - 1; x > 0; x--)
                begin
                    if (dist_lists[v][x] < dist_lists[v][x-1])
                    begin
                        swap = dist_lists[v][x];
                        dist_lists[v][x] = dist_lists[v][x-1];
                        dist_lists[v][x-1] = swap;
                    end
                end
            end
        end
        held_count = 0;
        for (int i = 0; i < int'(k); i++)
        begin
            r.distance = DIST_W'(dist_lists[n][i]);
            r.unreached = (dist_lists[n][i] == NO_PATH);
            r.last_result = (i + 1 == int'(k));
            target_distances.push_back(r);
        end
    endfunction

    function automatic void queue_edge(int unsigned src, int unsigned dst, int unsigned w,
                                       bit last);
        edge_item_t e;
        e.edge_from = VERTEX_W'(src);
        e.edge_to = VERTEX_W'(dst);
        e.edge_weight = WEIGHT_W'(w);
        e.edge_last = last;
        pending_edges.push_back(e);
    endfunction

    function automatic int unsigned pick_vertex(int unsigned n);
        case ($urandom_range(0, 3))
            0: return 1;
            1: return n;
            default: return $urandom_range(1, n);
        endcase
    endfunction

    function automatic int unsigned pick_weight();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 1000);
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_vertex_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'(1);
            2: return CFG_DATA_W'(MAX_V);
            3: return CFG_DATA_W'($urandom_range(MAX_V + 1, 127));
            default: return CFG_DATA_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_k_data();
        logic [CFG_DATA_W-1:0] k;
        case ($urandom_range(0, 7))
            0: k = '0;
            1: k = CFG_DATA_W'($urandom_range(MAX_KK + 1, 15));
            2: k = CFG_DATA_W'(MAX_KK);
            default: k = CFG_DATA_W'($urandom_range(1, MAX_KK));
        endcase
        // upper bits lie outside the k register
        if ($urandom_range(0, 3) == 0)
        begin
            k[CFG_DATA_W-1:KREG_W] = (CFG_DATA_W-KREG_W)'($urandom_range(1, 7));
        end
        return k;
    endfunction

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_NUM_VERTICES)
        begin
            vertices_reg = val[NUMV_W-1:0];
        end
        else if (idx == CFG_K_IN_USE)
        begin
            k_reg = val[KREG_W-1:0];
        end
    endtask

    task automatic wait_quiet();
        while (pending_edges.size() != 0 || start || target_distances.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : edge_driver
        bit took;
        if (rst_n)
        begin
            took = start && !busy;
            if (took)
            begin
                load_edge(edge_item);
            end
            if (!start || took)
            begin
                if (idle_left != 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (took && !steady && pending_edges.size() != 0
                         && $urandom_range(0, 99) < gap_pct)
                begin
                    idle_left = $urandom_range(0, 8);
                    start <= 1'b0;
                end
                else if (pending_edges.size() != 0)
                begin
                    edge_item <= pending_edges.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_valid)
        begin
            if (target_distances.size() == 0)
            begin
                $error("unexpected result: distance %0d unreached %0b last_result %0b",
                       result.distance, result.unreached, result.last_result);
                errors++;
            end
            else
            begin
                want = target_distances.pop_front();
                if (result.distance !== want.distance)
                begin
                    $error("distance: expected %0d, got %0d", want.distance, result.distance);
                    errors++;
                end
                if (result.unreached !== want.unreached)
                begin
                    $error("unreached: expected %0b, got %0b", want.unreached,
                           result.unreached);
                    errors++;
                end
                if (result.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0b, got %0b", want.last_result,
                           result.last_result);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("tb_k_shortest_distances_relaxation NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned n;
        int unsigned edges;
        int unsigned sent;
        bit overflow_done;
        sent = 0;
        overflow_done = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one vertex, one distance
        queue_edge(1, 1, 5, 1'b1);
        wait_quiet();

        program_register(CFG_NUM_VERTICES, 7'd4);
        program_register(CFG_K_IN_USE, 7'd3);
        queue_edge(1, 2, 0, 1'b0);
        queue_edge(2, 4, 65535, 1'b0);
        queue_edge(1, 4, 100, 1'b0);
        queue_edge(1, 3, 7, 1'b0);
        queue_edge(3, 4, 7, 1'b0);
        queue_edge(0, 4, 1, 1'b0);
        queue_edge(2, 127, 1, 1'b0);
        queue_edge(5, 4, 1, 1'b0);
        queue_edge(1, 4, 100, 1'b0);
        queue_edge(4, 4, 1, 1'b1);
        wait_quiet();

        program_register(CFG_NUM_VERTICES, 7'd0);
        program_register(CFG_K_IN_USE, 7'd0);
        queue_edge(1, 1, 3, 1'b1);
        wait_quiet();

        program_register(CFG_NUM_VERTICES, 7'd127);
        program_register(CFG_K_IN_USE, 7'd15);
        queue_edge(1, 64, 1, 1'b0);
        queue_edge(64, 64, 2, 1'b0);
        queue_edge(1, 64, 65535, 1'b0);
        queue_edge(127, 64, 0, 1'b0);
        queue_edge(64, 64, 0, 1'b1);
        wait_quiet();

        program_register(CFG_NUM_VERTICES, 7'd2);
        program_register(CFG_K_IN_USE, 7'd8);
        queue_edge(2, 1, 5, 1'b1);

        while (sent < 285)
        begin
            if (sent > 250)
            begin
                steady = 1'b1;
            end
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            if (!overflow_done && sent > 0)
            begin
                // fill the edge store; the dropped tail would give a zero distance
                wait_quiet();
                program_register(CFG_NUM_VERTICES, CFG_DATA_W'($urandom_range(2, 6)));
                program_register(CFG_K_IN_USE, CFG_DATA_W'($urandom_range(1, 2)));
                n = clamp_count(vertices_reg, MAX_V);
                edges = $urandom_range(MAX_E + 1, MAX_E + 3);
                for (int i = 0; i < int'(edges); i++)
                begin
                    if (i < MAX_E)
                    begin
                        queue_edge(pick_vertex(n), pick_vertex(n), (pick_weight() % 65535) + 1,
                                   i == int'(edges) - 1);
                    end
                    else
                    begin
                        queue_edge(1, n, 0, i == int'(edges) - 1);
                    end
                end
                sent += edges;
                overflow_done = 1'b1;
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                // long chain of heavy edges whose sum can cross the unreached value
                wait_quiet();
                program_register(CFG_NUM_VERTICES, 7'd17);
                program_register(CFG_K_IN_USE, CFG_DATA_W'($urandom_range(1, 3)));
                for (int i = 1; i <= 16; i++)
                begin
                    queue_edge(i, i + 1, $urandom_range(61000, 65535), i == 16);
                end
                sent += 16;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    wait_quiet();
                    if ($urandom_range(0, 2) != 0)
                    begin
                        program_register(CFG_NUM_VERTICES, pick_vertex_count());
                    end
                    if ($urandom_range(0, 2) != 0)
                    begin
                        program_register(CFG_K_IN_USE, pick_k_data());
                    end
                end
                n = clamp_count(vertices_reg, MAX_V);
                edges = $urandom_range(1, 12);
                for (int i = 0; i < int'(edges); i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        queue_edge($urandom_range(0, 127), $urandom_range(0, 127),
                                   pick_weight(), i == int'(edges) - 1);
                    end
                    else
                    begin
                        queue_edge(pick_vertex(n), pick_vertex(n), pick_weight(),
                                   i == int'(edges) - 1);
                    end
                end
                sent += edges;
            end
        end

        wait_quiet();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_k_shortest_distances_relaxation OK");
        end
        else
        begin
            $display("tb_k_shortest_distances_relaxation NOT OK");
        end
        $finish;
    end

endmodule
